>>> rtl/core/dvl_pkg.sv
// ----------------------------------------------------------------------------
// dvl_pkg
// shared types, constants and opcodes for the dvl frame transform
// ----------------------------------------------------------------------------
`default_nettype none
package dvl_pkg;
   localparam int VEC_WIDTH_DEF  = 24;
   localparam int QUAT_WIDTH_DEF = 16;
   localparam int RATE_FRAC      = 12;
   localparam int ACC_W          = 64;

   typedef enum logic [1:0] {
      OP_ORIENT = 2'd0,
      OP_VEL    = 2'd1,
      OP_POS    = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   // register indexes on the csr port
   localparam logic [1:0] CSR_LEVER = 2'd0;
   localparam logic [1:0] CSR_MOUNT = 2'd1;
   localparam logic [1:0] CSR_POOL  = 2'd2;

   localparam logic [63:0] IDENT_QUAT = 64'h4000_0000_0000_0000;
endpackage
`default_nettype wire

>>> rtl/core/dvl_serial_mac.sv
// ----------------------------------------------------------------------------
// dvl_serial_mac
// shift-add multiply-accumulate, one multiplier bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module dvl_serial_mac
   import dvl_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [ACC_W-1:0]  mcand,
   input  wire logic [ACC_W-1:0]  mplier,
   output logic                   busy,
   output logic [ACC_W-1:0]       product
);
   localparam int CW = $clog2(ACC_W + 1);

   logic [ACC_W-1:0] mc_ff, mc_in, mp_ff, mp_in, acc_ff, acc_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;

   // two's complement product modulo 2^64, lowest multiplier bit first
   always_comb begin
      mc_in   = mc_ff;
      mp_in   = mp_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         mc_in   = mcand;
         mp_in   = mplier;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mp_ff[0]) acc_in = acc_ff + mc_ff;
         mc_in  = {mc_ff[ACC_W-2:0], 1'b0};
         mp_in  = {1'b0, mp_ff[ACC_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (mp_in == '0 || cnt_ff == CW'(ACC_W - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
      acc_ff <= acc_in;
   end

   assign busy    = busy_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

>>> rtl/core/dvl_lever_arm_frame_transform.sv
// ----------------------------------------------------------------------------
// dvl_lever_arm_frame_transform
// sonar velocity / position samples to vehicle frame with lever-arm correction
// ----------------------------------------------------------------------------
// One item at a time. An orientation update stores attitude and rate. A
// velocity or position sample runs a microcoded sequence of products
// (52 for velocity, 30 for position) through one bit-serial multiply-accumulate
// unit; each product is started, shifted through its significant multiplier
// bits (all 64 for a negative multiplier) and then folded into the
// accumulator. The result sits in an output register until taken; the next
// item can be accepted in the cycle after the result is handed off.
`default_nettype none
module dvl_lever_arm_frame_transform
   import dvl_pkg::*;
#(
   parameter int VEC_WIDTH  = VEC_WIDTH_DEF,
   parameter int QUAT_WIDTH = QUAT_WIDTH_DEF
)(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // opcode travels as tuser
   input  wire logic [1:0]   req_tuser,
   // quat_w,quat_x,quat_y,quat_z,rate_x,rate_y,rate_z (16 each),
   // vec_x,vec_y,vec_z (VEC_WIDTH each), low to high, zero pad to bytes
   input  wire logic [((112 + 3*VEC_WIDTH + 7)/8)*8-1:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // result_kind, saturated, low to high
   output logic [1:0]        rsp_tuser,
   // out_x, out_y, out_z, low to high, zero pad to bytes
   output logic [((3*VEC_WIDTH + 7)/8)*8-1:0] rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [63:0]  csr_wdata
);
   localparam int QF  = QUAT_WIDTH - 2;
   localparam int OW  = ((3*VEC_WIDTH + 7)/8)*8;
   localparam int NR  = 32;     // scratch registers

   // microcode op codes
   typedef enum logic [2:0] {
      U_CLR, U_MAC, U_MSB, U_RND, U_RN2, U_CLP, U_ADD, U_END
   } uop_type;

   typedef struct packed {
      uop_type    op;
      logic [4:0] a;
      logic [4:0] b;
      logic [4:0] d;
      logic [5:0] s;   // shift for round
   } uinst_type;

   // ---------------- configuration and state registers
   logic [47:0] lever_ff;
   logic [63:0] mount_ff, pool_ff, att_ff;
   logic [47:0] rate_ff;

   // ---------------- scratch register file (fixed-place operands)
   logic [ACC_W-1:0] rf_ff [NR];
   logic [ACC_W-1:0] acc_ff;
   logic             kind_ff;
   state_type        st_ff, st_in;
   logic             mstart;
   logic             mbusy, mwait_ff;
   logic             msub_ff;
   logic [ACC_W-1:0] mprod;
   logic [3*VEC_WIDTH-1:0] odata_ff;
   logic             osat_ff;

   function automatic logic [ACC_W-1:0] sx16(input logic [15:0] v);
      return {{(ACC_W-16){v[15]}}, v};
   endfunction

   // register map: 0..3 q (w,x,y,z), 4..6 v, 7..9 t, 10..12 o,
   // 13..15 result acc, 16..19 mount, 20..22 lever,
   // 23..25 rate, 26..29 attitude, 30 scratch, 31 zero
   function automatic uinst_type ui(input uop_type o, input int a, input int b,
                                    input int d, input int s);
      uinst_type r;
      r.op = o; r.a = 5'(a); r.b = 5'(b); r.d = 5'(d); r.s = 6'(s);
      return r;
   endfunction

   // rotation of v(4..6) by q(0..3), result to o(10..12)
   function automatic uinst_type rot_step(input int k);
      uinst_type r;
      case (k)
         0:  r = ui(U_CLR,0,0,0,0);
         1:  r = ui(U_MAC,2,6,0,0);
         2:  r = ui(U_MSB,3,5,0,0);
         3:  r = ui(U_RN2,0,0,7,QF);
         4:  r = ui(U_CLR,0,0,0,0);
         5:  r = ui(U_MAC,3,4,0,0);
         6:  r = ui(U_MSB,1,6,0,0);
         7:  r = ui(U_RN2,0,0,8,QF);
         8:  r = ui(U_CLR,0,0,0,0);
         9:  r = ui(U_MAC,1,5,0,0);
         10: r = ui(U_MSB,2,4,0,0);
         11: r = ui(U_RN2,0,0,9,QF);
         12: r = ui(U_CLR,0,0,0,0);
         13: r = ui(U_MAC,0,7,0,0);
         14: r = ui(U_MAC,2,9,0,0);
         15: r = ui(U_MSB,3,8,0,0);
         16: r = ui(U_RND,0,0,10,QF);
         17: r = ui(U_CLR,0,0,0,0);
         18: r = ui(U_MAC,0,8,0,0);
         19: r = ui(U_MAC,3,7,0,0);
         20: r = ui(U_MSB,1,9,0,0);
         21: r = ui(U_RND,0,0,11,QF);
         22: r = ui(U_CLR,0,0,0,0);
         23: r = ui(U_MAC,0,9,0,0);
         24: r = ui(U_MAC,1,8,0,0);
         25: r = ui(U_MSB,2,7,0,0);
         26: r = ui(U_RND,0,0,12,QF);
         default: r = ui(U_END,0,0,0,0);
      endcase
      return r;
   endfunction

   // program: pc 0..  indices below
   // phase A (rotate #1): q from the attitude-mount product (velocity) or pool (position), v = sample
   // a uop U_ADD d,a,b : no action, it falls to the default branch
   logic [4:0] seg_ff;     // sequence segment
   logic [4:0] rk_ff;      // step inside rotation

   // segments for velocity:
   //  0 qmul(att,mount)->q, 1 rotate, 2 save o->13..15 (= v+rot), 3 cross -> v,
   //  4 load att->q, 5 rotate, 6 result = 13..15 - v - o, 7 clamp, done
   // position: 0 load pool->q, 1 rotate, 2 save, 3 neg lever -> v, 4 load att,
   //  5 rotate, 6 result = 13..15 + lever + v + o
   function automatic uinst_type qm_step(input int k);
      // r.w,x,y,z into 0..3 from attitude 26..29 and mount 16..19
      uinst_type r;
      case (k)
         0:  r = ui(U_CLR,0,0,0,0);
         1:  r = ui(U_MAC,26,16,0,0);
         2:  r = ui(U_MSB,27,17,0,0);
         3:  r = ui(U_MSB,28,18,0,0);
         4:  r = ui(U_MSB,29,19,0,0);
         5:  r = ui(U_CLP,0,0,0,QF);
         6:  r = ui(U_CLR,0,0,0,0);
         7:  r = ui(U_MAC,26,17,0,0);
         8:  r = ui(U_MAC,27,16,0,0);
         9:  r = ui(U_MAC,28,19,0,0);
         10: r = ui(U_MSB,29,18,0,0);
         11: r = ui(U_CLP,0,0,1,QF);
         12: r = ui(U_CLR,0,0,0,0);
         13: r = ui(U_MAC,26,18,0,0);
         14: r = ui(U_MSB,27,19,0,0);
         15: r = ui(U_MAC,28,16,0,0);
         16: r = ui(U_MAC,29,17,0,0);
         17: r = ui(U_CLP,0,0,2,QF);
         18: r = ui(U_CLR,0,0,0,0);
         19: r = ui(U_MAC,26,19,0,0);
         20: r = ui(U_MAC,27,18,0,0);
         21: r = ui(U_MSB,28,17,0,0);
         22: r = ui(U_MAC,29,16,0,0);
         23: r = ui(U_CLP,0,0,3,QF);
         default: r = ui(U_END,0,0,0,0);
      endcase
      return r;
   endfunction

   function automatic uinst_type cr_step(input int k);
      // rate 23..25 x lever 20..22 -> v 4..6, round by RATE_FRAC
      uinst_type r;
      case (k)
         0:  r = ui(U_CLR,0,0,0,0);
         1:  r = ui(U_MAC,24,22,0,0);
         2:  r = ui(U_MSB,25,21,0,0);
         3:  r = ui(U_RND,0,0,4,RATE_FRAC);
         4:  r = ui(U_CLR,0,0,0,0);
         5:  r = ui(U_MAC,25,20,0,0);
         6:  r = ui(U_MSB,23,22,0,0);
         7:  r = ui(U_RND,0,0,5,RATE_FRAC);
         8:  r = ui(U_CLR,0,0,0,0);
         9:  r = ui(U_MAC,23,21,0,0);
         10: r = ui(U_MSB,24,20,0,0);
         11: r = ui(U_RND,0,0,6,RATE_FRAC);
         default: r = ui(U_END,0,0,0,0);
      endcase
      return r;
   endfunction

   uinst_type cur;
   always_comb begin
      case (seg_ff)
         5'd0:    cur = kind_ff ? ui(U_END,0,0,0,0) : qm_step(int'(rk_ff));
         5'd1, 5'd5: cur = rot_step(int'(rk_ff));
         5'd3:    cur = kind_ff ? ui(U_END,0,0,0,0) : cr_step(int'(rk_ff));
         default: cur = ui(U_END,0,0,0,0);
      endcase
   end

   // rounding: floor((a + 2^(s-1)) >> s), arithmetic
   function automatic logic [ACC_W-1:0] rnd(input logic [ACC_W-1:0] a,
                                            input logic [5:0] s);
      logic [ACC_W-1:0] t;
      t = a + (ACC_W'(1) << (s - 6'd1));
      return ACC_W'($signed(t) >>> s);
   endfunction

   function automatic logic [ACC_W-1:0] clp16(input logic [ACC_W-1:0] v);
      logic [ACC_W-1:0] r;
      if ($signed(v) > 64'sd32767) r = ACC_W'(32767);
      else if ($signed(v) < -64'sd32768) r = {{(ACC_W-15){1'b1}}, 15'd0};
      else r = v;
      return r;
   endfunction

   logic req_acc, rsp_acc;
   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;
   assign req_tready = (st_ff == ST_IDLE);
   assign rsp_tvalid = (st_ff == ST_DONE);

   dvl_serial_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .start   (mstart),
      .mcand   (rf_ff[cur.a]),
      .mplier  (rf_ff[cur.b]),
      .busy    (mbusy),
      .product (mprod)
   );

   logic step_en;
   assign step_en = (st_ff == ST_RUN) && !mbusy && !mwait_ff;
   assign mstart  = step_en && (cur.op == U_MAC || cur.op == U_MSB);

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (req_acc && (req_tuser == OP_VEL || req_tuser == OP_POS))
                     st_in = ST_RUN;
         ST_RUN:  if (step_en && seg_ff == 5'd7) st_in = ST_DONE;
         ST_DONE: if (rsp_acc) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // saturation of final components
   logic [ACC_W-1:0] hi_lim, lo_lim;
   assign hi_lim = (ACC_W'(1) << (VEC_WIDTH-1)) - 1'b1;
   assign lo_lim = ~hi_lim;

   logic [3*VEC_WIDTH-1:0] sat_data;
   logic                   sat_flag;
   always_comb begin
      sat_data = '0;
      sat_flag = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if ($signed(rf_ff[13+i]) > $signed(hi_lim)) begin
            sat_data[i*VEC_WIDTH +: VEC_WIDTH] = hi_lim[VEC_WIDTH-1:0];
            sat_flag = 1'b1;
         end else if ($signed(rf_ff[13+i]) < $signed(lo_lim)) begin
            sat_data[i*VEC_WIDTH +: VEC_WIDTH] = lo_lim[VEC_WIDTH-1:0];
            sat_flag = 1'b1;
         end else begin
            sat_data[i*VEC_WIDTH +: VEC_WIDTH] = rf_ff[13+i][VEC_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         lever_ff <= '0;
         mount_ff <= IDENT_QUAT;
         pool_ff  <= IDENT_QUAT;
         att_ff   <= IDENT_QUAT;
         rate_ff  <= '0;
         mwait_ff <= 1'b0;
         seg_ff   <= '0;
         rk_ff    <= '0;
      end else begin
         st_ff <= st_in;
         if (csr_we) begin
            case (csr_index)
               CSR_LEVER: lever_ff <= csr_wdata[47:0];
               CSR_MOUNT: mount_ff <= csr_wdata;
               CSR_POOL:  pool_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (req_acc && req_tuser == OP_ORIENT) begin
            att_ff  <= {req_tdata[15:0], req_tdata[31:16],
                        req_tdata[47:32], req_tdata[63:48]};
            rate_ff <= {req_tdata[79:64], req_tdata[95:80], req_tdata[111:96]};
         end
         // after a multiply, wait for it to finish, then fold the product
         mwait_ff <= mstart ? 1'b1 : (mbusy ? mwait_ff : 1'b0);
         if (req_acc) begin
            seg_ff <= '0;
            rk_ff  <= '0;
         end else if (step_en) begin
            if (cur.op == U_END) begin
               seg_ff <= seg_ff + 1'b1;
               rk_ff  <= '0;
            end else begin
               rk_ff <= rk_ff + 1'b1;
            end
         end
      end
      // ---------------- datapath
      if (req_acc) begin
         kind_ff <= (req_tuser == OP_POS);
         rf_ff[4]  <= ACC_W'($signed(req_tdata[112 +: VEC_WIDTH]));
         rf_ff[5]  <= ACC_W'($signed(req_tdata[112+VEC_WIDTH +: VEC_WIDTH]));
         rf_ff[6]  <= ACC_W'($signed(req_tdata[112+2*VEC_WIDTH +: VEC_WIDTH]));
         rf_ff[20] <= sx16(lever_ff[47:32]);
         rf_ff[21] <= sx16(lever_ff[31:16]);
         rf_ff[22] <= sx16(lever_ff[15:0]);
         rf_ff[23] <= sx16(rate_ff[47:32]);
         rf_ff[24] <= sx16(rate_ff[31:16]);
         rf_ff[25] <= sx16(rate_ff[15:0]);
         rf_ff[26] <= sx16(att_ff[63:48]);
         rf_ff[27] <= sx16(att_ff[47:32]);
         rf_ff[28] <= sx16(att_ff[31:16]);
         rf_ff[29] <= sx16(att_ff[15:0]);
         rf_ff[31] <= '0;
         if (req_tuser == OP_POS) begin
            rf_ff[0] <= sx16(pool_ff[63:48]);
            rf_ff[1] <= sx16(pool_ff[47:32]);
            rf_ff[2] <= sx16(pool_ff[31:16]);
            rf_ff[3] <= sx16(pool_ff[15:0]);
         end
         rf_ff[16] <= sx16(mount_ff[63:48]);
         rf_ff[17] <= sx16(mount_ff[47:32]);
         rf_ff[18] <= sx16(mount_ff[31:16]);
         rf_ff[19] <= sx16(mount_ff[15:0]);
      end else if (mwait_ff && !mbusy) begin
         acc_ff <= msub_ff ? acc_ff - mprod : acc_ff + mprod;
      end else if (step_en) begin
         case (cur.op)
            U_CLR: acc_ff <= '0;
            // remember the sign of the product being started
            U_MAC, U_MSB: msub_ff <= (cur.op == U_MSB);
            U_RND: rf_ff[cur.d] <= rnd(acc_ff, cur.s);
            // doubled sum before rounding
            U_RN2: rf_ff[cur.d] <= rnd(acc_ff << 1, cur.s);
            U_CLP: rf_ff[cur.d] <= clp16(rnd(acc_ff, cur.s));
            U_END: begin
               case (seg_ff)
                  5'd2: begin
                     rf_ff[13] <= rf_ff[4] + rf_ff[10];
                     rf_ff[14] <= rf_ff[5] + rf_ff[11];
                     rf_ff[15] <= rf_ff[6] + rf_ff[12];
                  end
                  5'd3: if (kind_ff) begin
                     rf_ff[4] <= -rf_ff[20];
                     rf_ff[5] <= -rf_ff[21];
                     rf_ff[6] <= -rf_ff[22];
                  end
                  5'd4: begin
                     rf_ff[0] <= rf_ff[26];
                     rf_ff[1] <= rf_ff[27];
                     rf_ff[2] <= rf_ff[28];
                     rf_ff[3] <= rf_ff[29];
                  end
                  5'd6: begin
                     if (kind_ff) begin
                        rf_ff[13] <= rf_ff[13] + rf_ff[20] + rf_ff[4] + rf_ff[10];
                        rf_ff[14] <= rf_ff[14] + rf_ff[21] + rf_ff[5] + rf_ff[11];
                        rf_ff[15] <= rf_ff[15] + rf_ff[22] + rf_ff[6] + rf_ff[12];
                     end else begin
                        rf_ff[13] <= rf_ff[13] - rf_ff[4] - rf_ff[10];
                        rf_ff[14] <= rf_ff[14] - rf_ff[5] - rf_ff[11];
                        rf_ff[15] <= rf_ff[15] - rf_ff[6] - rf_ff[12];
                     end
                  end
                  5'd7: begin
                     odata_ff <= sat_data;
                     osat_ff  <= sat_flag;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   assign rsp_tdata = OW'(odata_ff);
   assign rsp_tuser = {osat_ff, kind_ff};
endmodule
`default_nettype wire

>>> bench/dvl_lever_arm_frame_transform_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dvl_lever_arm_frame_transform_tb
// self-checking bench for the sonar to vehicle frame transform
// ----------------------------------------------------------------------------
// a queue of pending items feeds a clocked driver; each accepted item goes
// through an in-bench fixed point model of the transform and any velocity or
// position result is queued, then matched field by field against the block
// output. phases change the mounting registers and the idling pattern
// ----------------------------------------------------------------------------
module dvl_lever_arm_frame_transform_tb
   import dvl_pkg::*;
();

   localparam int VW = 24;
   localparam int QF = 14;
   localparam int DW = ((112 + 3*VW + 7)/8)*8;
   localparam int RW = ((3*VW + 7)/8)*8;

   typedef struct {
      opcode_type  op;
      logic [15:0] qw, qx, qy, qz, rx, ry, rz;
      logic [VW-1:0] vx, vy, vz;
   } sample_type;

   typedef struct {
      logic          kind;
      logic [VW-1:0] x, y, z;
      logic          sat;
   } frame_out_type;

   typedef struct { longint w, x, y, z; } quat_type;
   typedef longint vec3_type [3];

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [1:0]        req_tuser;   // opcode
   // quat_w,quat_x,quat_y,quat_z,rate_x,rate_y,rate_z,vec_x,vec_y,vec_z low up
   logic [DW-1:0]     req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [1:0]        rsp_tuser;   // result_kind, saturated low up
   logic [RW-1:0]     rsp_tdata;   // out_x, out_y, out_z low up
   logic              csr_we;
   logic [1:0]        csr_index;
   logic [63:0]       csr_wdata;

   dvl_lever_arm_frame_transform dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // model copy of registers and state
   logic [47:0] lever_reg;
   logic [63:0] mount_reg, pool_reg, attitude_reg;
   logic [47:0] rate_reg;

   sample_type     pending_items[$];
   frame_out_type  expected_frames[$];
   sample_type     cur_item;
   int             fail_count;
   int             send_idle_pct, recv_idle_pct;
   int             hold_cycles = 0;
   int             hold_req;
   int             hold_seen = 0;

   // clock
   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // fixed point model
   function automatic longint rnd(longint a, int s);
      return (a + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint sx16(logic [15:0] v);
      return longint'($signed(v));
   endfunction

   function automatic quat_type unpack_q(logic [63:0] p);
      quat_type q;
      q.w = sx16(p[63:48]);
      q.x = sx16(p[47:32]);
      q.y = sx16(p[31:16]);
      q.z = sx16(p[15:0]);
      return q;
   endfunction

   function automatic longint clamp_lane(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic quat_type quat_product(quat_type a, quat_type b);
      quat_type r;
      r.w = clamp_lane(rnd(a.w*b.w - a.x*b.x - a.y*b.y - a.z*b.z, QF));
      r.x = clamp_lane(rnd(a.w*b.x + a.x*b.w + a.y*b.z - a.z*b.y, QF));
      r.y = clamp_lane(rnd(a.w*b.y - a.x*b.z + a.y*b.w + a.z*b.x, QF));
      r.z = clamp_lane(rnd(a.w*b.z + a.x*b.y - a.y*b.x + a.z*b.w, QF));
      return r;
   endfunction

   // unit quaternion rotation: v + qw*t + u x t with t = 2 u x v
   function automatic vec3_type rotate_vec(quat_type q, vec3_type v);
      longint t[3];
      longint c[3];
      vec3_type o;
      t[0] = rnd(2*(q.y*v[2] - q.z*v[1]), QF);
      t[1] = rnd(2*(q.z*v[0] - q.x*v[2]), QF);
      t[2] = rnd(2*(q.x*v[1] - q.y*v[0]), QF);
      c[0] = q.y*t[2] - q.z*t[1];
      c[1] = q.z*t[0] - q.x*t[2];
      c[2] = q.x*t[1] - q.y*t[0];
      for (int i = 0; i < 3; i++) o[i] = v[i] + rnd(q.w*t[i] + c[i], QF);
      return o;
   endfunction

   // advance the model by one accepted item
   task automatic transform_item(sample_type s);
      vec3_type v, lev, a, b, cr, neg;
      longint res[3];
      longint hi, lo, wx, wy, wz;
      frame_out_type f;
      quat_type qa;
      hi = (longint'(1) <<< (VW - 1)) - 1;
      lo = -hi - 1;
      qa = unpack_q(attitude_reg);
      if (s.op == OP_ORIENT) begin
         attitude_reg = {s.qw, s.qx, s.qy, s.qz};
         rate_reg = {s.rx, s.ry, s.rz};
         return;
      end
      if (s.op == OP_NONE) return;
      v[0] = longint'($signed(s.vx));
      v[1] = longint'($signed(s.vy));
      v[2] = longint'($signed(s.vz));
      lev[0] = sx16(lever_reg[47:32]);
      lev[1] = sx16(lever_reg[31:16]);
      lev[2] = sx16(lever_reg[15:0]);
      if (s.op == OP_VEL) begin
         wx = sx16(rate_reg[47:32]);
         wy = sx16(rate_reg[31:16]);
         wz = sx16(rate_reg[15:0]);
         cr[0] = rnd(wy*lev[2] - wz*lev[1], RATE_FRAC);
         cr[1] = rnd(wz*lev[0] - wx*lev[2], RATE_FRAC);
         cr[2] = rnd(wx*lev[1] - wy*lev[0], RATE_FRAC);
         a = rotate_vec(quat_product(qa, unpack_q(mount_reg)), v);
         b = rotate_vec(qa, cr);
         for (int i = 0; i < 3; i++) res[i] = a[i] - b[i];
      end else begin
         for (int i = 0; i < 3; i++) neg[i] = -lev[i];
         a = rotate_vec(unpack_q(pool_reg), v);
         b = rotate_vec(qa, neg);
         for (int i = 0; i < 3; i++) res[i] = a[i] + lev[i] + b[i];
      end
      f.kind = (s.op == OP_POS);
      f.sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (res[i] > hi) begin res[i] = hi; f.sat = 1'b1; end
         if (res[i] < lo) begin res[i] = lo; f.sat = 1'b1; end
      end
      f.x = res[0][VW-1:0];
      f.y = res[1][VW-1:0];
      f.z = res[2][VW-1:0];
      expected_frames.push_back(f);
   endtask

   // driver: accept seen at the rising edge, next item put up at the falling edge
   logic req_taken;
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         req_taken = 1'b1;
         transform_item(cur_item);
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_taken)) begin
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            cur_item = pending_items.pop_front();
            req_tuser <= cur_item.op;
            req_tdata <= {cur_item.vz, cur_item.vy, cur_item.vx, cur_item.rz,
                          cur_item.ry, cur_item.rx, cur_item.qz, cur_item.qy,
                          cur_item.qx, cur_item.qw};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, with a long hold-off counted here
   always @(negedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_cycles <= 30000;
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      frame_out_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_frames.size() == 0) begin
            $error("result with nothing expected: %h %h", rsp_tuser, rsp_tdata);
            fail_count++;
         end else begin
            e = expected_frames.pop_front();
            if (rsp_tuser[0] !== e.kind) begin
               $error("result_kind expected %0d got %0d", e.kind, rsp_tuser[0]);
               fail_count++;
            end
            if (rsp_tdata[VW-1:0] !== e.x) begin
               $error("out_x expected %0d got %0d", $signed(e.x),
                      $signed(rsp_tdata[VW-1:0]));
               fail_count++;
            end
            if (rsp_tdata[2*VW-1:VW] !== e.y) begin
               $error("out_y expected %0d got %0d", $signed(e.y),
                      $signed(rsp_tdata[2*VW-1:VW]));
               fail_count++;
            end
            if (rsp_tdata[3*VW-1:2*VW] !== e.z) begin
               $error("out_z expected %0d got %0d", $signed(e.z),
                      $signed(rsp_tdata[3*VW-1:2*VW]));
               fail_count++;
            end
            if (rsp_tuser[1] !== e.sat) begin
               $error("saturated expected %0d got %0d", e.sat, rsp_tuser[1]);
               fail_count++;
            end
         end
      end
   end

   // register write, only while the block is idle
   task automatic csr_write(logic [1:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_LEVER: lever_reg = val[47:0];
         CSR_MOUNT: mount_reg = val;
         CSR_POOL: pool_reg = val;
         default: ;
      endcase
   endtask

   // drained: nothing queued, nothing in flight, nothing owed
   task automatic wait_drained();
      wait (pending_items.size() == 0 && !req_tvalid && expected_frames.size() == 0);
      // an orientation update leaves no result, give it time to retire
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_lane();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         default: return 16'($urandom());
      endcase
   endfunction

   // unit-ish quaternion lane set: mostly well-formed rotations
   function automatic logic [63:0] rand_quat();
      case ($urandom_range(7))
         0: return IDENT_QUAT;
         1: return {16'sd11585, 16'sd11585, 16'sd0, 16'sd0};
         2: return {16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192};
         3: return {16'sd11585, 16'sd0, -16'sd11585, 16'sd0};
         4: return {16'sd0, 16'sd0, 16'sd0, 16'sd16384};
         5: return {16'sd15137, 16'sd0, 16'sd0, 16'sd6270};
         default: return {rand_lane(), rand_lane(), rand_lane(), rand_lane()};
      endcase
   endfunction

   function automatic logic [VW-1:0] rand_vec();
      case ($urandom_range(7))
         0: return {1'b1, {(VW-1){1'b0}}};
         1: return {1'b0, {(VW-1){1'b1}}};
         2: return VW'($urandom_range(4000)) - VW'(2000);
         default: return VW'($urandom());
      endcase
   endfunction

   function automatic sample_type rand_item();
      sample_type s;
      int pick;
      logic [63:0] q;
      pick = $urandom_range(99);
      if (pick < 20) s.op = OP_ORIENT;
      else if (pick < 55) s.op = OP_VEL;
      else if (pick < 92) s.op = OP_POS;
      else s.op = OP_NONE;
      q = rand_quat();
      {s.qw, s.qx, s.qy, s.qz} = q;
      s.rx = rand_lane();
      s.ry = rand_lane();
      s.rz = rand_lane();
      s.vx = rand_vec();
      s.vy = rand_vec();
      s.vz = rand_vec();
      return s;
   endfunction

   function automatic sample_type make_item(opcode_type op, logic [63:0] q,
                                            logic [47:0] r, logic [VW-1:0] v);
      sample_type s;
      s.op = op;
      {s.qw, s.qx, s.qy, s.qz} = q;
      {s.rx, s.ry, s.rz} = r;
      s.vx = v;
      s.vy = -v;
      s.vz = v ^ 24'h5a5a5a;
      return s;
   endfunction

   initial begin
      logic [VW-1:0] vmax, vmin;
      vmax = {1'b0, {(VW-1){1'b1}}};
      vmin = {1'b1, {(VW-1){1'b0}}};
      fail_count = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      hold_req = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      lever_reg = '0;
      mount_reg = IDENT_QUAT;
      pool_reg = IDENT_QUAT;
      attitude_reg = IDENT_QUAT;
      rate_reg = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset state, then extremes of registers and fields
      pending_items.push_back(make_item(OP_VEL, 64'h0, 48'h0, 24'd1000));
      pending_items.push_back(make_item(OP_POS, 64'h0, 48'h0, vmax));
      pending_items.push_back(make_item(OP_NONE, 64'hffff_ffff_ffff_ffff,
                                        48'hffff_ffff_ffff, vmin));
      wait_drained();
      csr_write(CSR_LEVER, 64'h0000_7fff_8000_7fff);
      csr_write(CSR_MOUNT, 64'h8000_8000_8000_8000);
      csr_write(CSR_POOL, 64'h7fff_7fff_7fff_7fff);
      // orientation with extreme rate, then samples at field extremes
      pending_items.push_back(make_item(OP_ORIENT, {16'sd11585, 16'sd11585, 32'h0},
                                        48'h7fff_8000_7fff, '0));
      pending_items.push_back(make_item(OP_VEL, '0, '0, vmax));
      pending_items.push_back(make_item(OP_VEL, '0, '0, vmin));
      pending_items.push_back(make_item(OP_POS, '0, '0, vmax));
      pending_items.push_back(make_item(OP_POS, '0, '0, vmin));
      // non-unit attitude used as given
      pending_items.push_back(make_item(OP_ORIENT, 64'h8000_7fff_8000_7fff,
                                        48'h8000_7fff_8000, '0));
      pending_items.push_back(make_item(OP_VEL, '0, '0, 24'd12345));
      pending_items.push_back(make_item(OP_POS, '0, '0, 24'hfff000));
      pending_items.push_back(make_item(OP_NONE, '0, '0, vmax));
      pending_items.push_back(make_item(OP_VEL, '0, '0, 24'd0));
      wait_drained();
      csr_write(CSR_LEVER, 64'h0000_8000_8000_8000);
      csr_write(CSR_MOUNT, 64'h0);
      csr_write(CSR_POOL, 64'h8000_0000_0000_0000);
      pending_items.push_back(make_item(OP_ORIENT, 64'h8000_8000_8000_8000,
                                        48'h8000_8000_8000, '0));
      pending_items.push_back(make_item(OP_VEL, '0, '0, vmin));
      pending_items.push_back(make_item(OP_POS, '0, '0, vmin));
      pending_items.push_back(make_item(OP_POS, '0, '0, 24'd1));
      wait_drained();

      // random phases, each with its own mounting and idling pattern
      for (int ph = 0; ph < 3; ph++) begin
         csr_write(CSR_LEVER, {16'h0,
                               ($urandom_range(1) != 0) ? 16'($urandom()) : 16'd300,
                               16'($urandom()), 16'($urandom())});
         csr_write(CSR_MOUNT, rand_quat());
         csr_write(CSR_POOL, rand_quat());
         send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 48 : 0;
         recv_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 8 : 0;
         for (int n = 0; n < 178; n++) pending_items.push_back(rand_item());
         if (ph == 2) begin
            // long hold-off while items keep coming, so the input backs up
            @(negedge clock);
            hold_req <= hold_req + 1;
         end
         wait_drained();
      end
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #400ms;
      $display("simulation failed");
      $finish;
   end

endmodule
